// File: sv/seen_device_table_lru_macros.svh
// Assertion helpers for the seen device table.
// All checks sample on i_clk and are off while i_rst_n is low.
`ifndef SEEN_DEVICE_TABLE_LRU_MACROS_SVH
`define SEEN_DEVICE_TABLE_LRU_MACROS_SVH

// Same-cycle implication
`define SDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdt_pkg;

    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;

    // Input word: address in the low bits, time above it
    localparam int IN_DATA_W  = 80;
    // Output word: hit, slot, evicted, first_seen, zero pad
    localparam int OUT_DATA_W = 40;

    // One table entry as stored in memory
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] last_seen;
        logic [TIME_W-1:0] first_seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// File: sv/sdt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire [WIDTH-1:0]          i_wr_data,
    input  wire                      i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/seen_device_table_lru.sv
`timescale 1ns / 1ps
`default_nettype none

// Table of recently seen 48-bit device addresses with LRU replacement. Each input
// word is one sighting (address, current time) and gives exactly one output word:
// hit flag, slot, evicted flag and the slot's first-seen time. Address and times
// live in one RAM with a single read port, which is walked one entry per cycle
// for every sighting; valid bits are flip-flops cleared at reset, so no clearing
// pass is needed. Each sighting passes through these steps in order: the accept,
// RAM reads issued for every entry, a check of the last entry read (the RAM read
// is registered), the close of the scan, and the write-back of the entry together
// with the loading of the output register. The input is taken again as soon as
// the output word is loaded, even while it waits for m_axis_tready; the next
// write-back then waits until that word is taken.
`include "seen_device_table_lru_macros.svh"

module seen_device_table_lru #(
    parameter int ENTRIES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // s_axis_tdata: [47:0] device_address, [79:48] now_time
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [79:0]  s_axis_tdata,
    // m_axis_tdata: [0] hit, [4:1] slot, [5] evicted_valid, [37:6] first_seen,
    // [39:38] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] SCAN_END = CW'(ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [sdt_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [sdt_pkg::TIME_W-1:0]   r_now, n_now;
    logic [CW-1:0]                r_rd_cnt, n_rd_cnt;
    logic                         r_chk_vld, n_chk_vld;
    logic [IW-1:0]                r_chk_idx, n_chk_idx;
    logic                         r_hit, n_hit;
    logic [IW-1:0]                r_hit_idx, n_hit_idx;
    logic [sdt_pkg::TIME_W-1:0]   r_hit_first, n_hit_first;
    logic                         r_have_inv, n_have_inv;
    logic [IW-1:0]                r_inv_idx, n_inv_idx;
    logic [IW-1:0]                r_best_idx, n_best_idx;
    logic [sdt_pkg::TIME_W-1:0]   r_best_time, n_best_time;
    logic [ENTRIES-1:0]           r_valid, n_valid;
    logic                         r_out_vld, n_out_vld;
    logic [39:0]                  r_out_data, n_out_data;

    logic                         w_rd_en;
    logic                         w_wr_en;
    logic                         w_load;
    logic [IW-1:0]                w_slot;
    logic                         w_evicted;
    logic [sdt_pkg::ENTRY_W-1:0]  w_rd_raw;
    sdt_pkg::t_entry              w_rd_entry;
    sdt_pkg::t_entry              w_wr_entry;

    // Entry store
    sdt_ram #(
        .WIDTH (sdt_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_cnt[IW-1:0]),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd_entry = sdt_pkg::t_entry'(w_rd_raw);

    // Target slot: matching entry, else first invalid, else oldest below now, else slot 0
    assign w_slot    = r_hit ? r_hit_idx : (r_have_inv ? r_inv_idx : r_best_idx);
    assign w_evicted = !r_hit && !r_have_inv;

    assign w_wr_entry.addr       = r_addr;
    assign w_wr_entry.last_seen  = r_now;
    assign w_wr_entry.first_seen = r_hit ? r_hit_first : r_now;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_now       = r_now;
        n_rd_cnt    = r_rd_cnt;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_first = r_hit_first;
        n_have_inv  = r_have_inv;
        n_inv_idx   = r_inv_idx;
        n_best_idx  = r_best_idx;
        n_best_time = r_best_time;
        n_valid     = r_valid;
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_load      = 1'b0;

        // output word taken
        if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_addr      = s_axis_tdata[47:0];
                    n_now       = s_axis_tdata[79:48];
                    n_rd_cnt    = '0;
                    n_chk_vld   = 1'b0;
                    n_hit       = 1'b0;
                    n_have_inv  = 1'b0;
                    n_best_idx  = '0;
                    n_best_time = s_axis_tdata[79:48];
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue reads, one entry per cycle
                if (r_rd_cnt != SCAN_END) begin
                    w_rd_en  = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                n_chk_vld = (r_rd_cnt != SCAN_END);
                n_chk_idx = r_rd_cnt[IW-1:0];

                // check the entry read last cycle
                if (r_chk_vld) begin
                    if (r_valid[r_chk_idx]) begin
                        if (!r_hit && (w_rd_entry.addr == r_addr)) begin
                            n_hit       = 1'b1;
                            n_hit_idx   = r_chk_idx;
                            n_hit_first = w_rd_entry.first_seen;
                        end
                        if (w_rd_entry.last_seen < r_best_time) begin
                            n_best_time = w_rd_entry.last_seen;
                            n_best_idx  = r_chk_idx;
                        end
                    end else if (!r_have_inv) begin
                        n_have_inv = 1'b1;
                        n_inv_idx  = r_chk_idx;
                    end
                end

                if (!r_chk_vld && (r_rd_cnt == SCAN_END)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // write back and load the output word together
                if (!r_out_vld || m_axis_tready) begin
                    w_load           = 1'b1;
                    w_wr_en          = 1'b1;
                    n_valid[w_slot]  = 1'b1;
                    n_out_vld        = 1'b1;
                    n_out_data       = {2'b00, w_wr_entry.first_seen, w_evicted,
                                        sdt_pkg::SLOT_W'(w_slot), r_hit};
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_cnt  <= '0;
            r_chk_vld <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_chk_vld <= n_chk_vld;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload and scan results, no reset
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_now       <= n_now;
        r_chk_idx   <= n_chk_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_first <= n_hit_first;
        r_have_inv  <= n_have_inv;
        r_inv_idx   <= n_inv_idx;
        r_best_idx  <= n_best_idx;
        r_best_time <= n_best_time;
        r_out_data  <= n_out_data;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Checks
    `SDT_ASSERT_NEXT(a_accept_starts_scan, s_axis_tvalid && s_axis_tready,
        r_state == S_SCAN && r_rd_cnt == '0, "accepted word did not start a scan")
    `SDT_ASSERT_NOW(a_cnt_bound, 1'b1, r_rd_cnt <= SCAN_END,
        "scan counter ran past the table")
    `SDT_ASSERT_NOW(a_hit_on_valid, w_load && r_hit, r_valid[r_hit_idx],
        "hit reported on an invalid entry")
    `SDT_ASSERT_NEXT(a_load_sets_valid, w_load,
        m_axis_tvalid && r_valid[$past(w_slot)], "written slot not marked valid")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 500;
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 8;
    localparam int ROW_COUNT    = 22;

    // One output word, unpacked
    typedef struct packed {
        logic                       hit;
        logic [sdt_pkg::SLOT_W-1:0] slot;
        logic                       evicted;
        logic [sdt_pkg::TIME_W-1:0] first_seen;
    } t_sighting_result;

    typedef struct packed {
        logic [sdt_pkg::ADDR_W-1:0] addr;
        logic [sdt_pkg::TIME_W-1:0] now;
        logic                       typed;
        t_sighting_result           want;
    } t_directed_row;

    localparam t_sighting_result UNTYPED = '0;

    // Directed sightings; typed rows carry the word they must give
    localparam t_directed_row DIRECTED_ROWS [0:ROW_COUNT-1] = '{
        // empty table: first free slots
        '{48'h0000_0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0, 32'h0000_0000}},
        '{48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 32'hFFFF_FFFF}},
        // refresh of slot 0 keeps its first-seen time, no eviction on a hit
        '{48'h0000_0000_0000, 32'd5,         1'b1, '{1'b1, 4'd0, 1'b0, 32'h0000_0000}},
        // fill the remaining slots
        '{48'hA5A5_0000_0002, 32'd10, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0003, 32'd11, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0004, 32'd12, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0005, 32'd13, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0006, 32'd14, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0007, 32'd15, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0008, 32'd16, 1'b0, UNTYPED},
        '{48'hA5A5_0000_0009, 32'd17, 1'b0, UNTYPED},
        '{48'hA5A5_0000_000A, 32'd18, 1'b0, UNTYPED},
        '{48'hA5A5_0000_000B, 32'd19, 1'b0, UNTYPED},
        '{48'hA5A5_0000_000C, 32'd20, 1'b0, UNTYPED},
        '{48'hA5A5_0000_000D, 32'd21, 1'b0, UNTYPED},
        '{48'hA5A5_0000_000E, 32'd22, 1'b0, UNTYPED},
        '{48'hA5A5_0000_000F, 32'd23, 1'b0, UNTYPED},
        // full table, time behind every entry: slot 0 is overwritten
        '{48'h1234_5678_9ABC, 32'd3,         1'b1, '{1'b0, 4'd0, 1'b1, 32'd3}},
        // full table, oldest entry replaced
        '{48'h5A5A_5A5A_5A5A, 32'd100,       1'b0, UNTYPED},
        // refresh of slot 1 with the top time bit set
        '{48'hFFFF_FFFF_FFFF, 32'h8000_0000, 1'b0, UNTYPED},
        // hit on the last slot
        '{48'hA5A5_0000_000F, 32'd30,        1'b0, UNTYPED},
        // nothing below time zero: slot 0 again
        '{48'h0000_0000_0001, 32'd0,         1'b1, '{1'b0, 4'd0, 1'b1, 32'd0}}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sdt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [sdt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow copy of the table
    logic                       shadow_valid     [TABLE_DEPTH];
    logic [sdt_pkg::ADDR_W-1:0] shadow_addr      [TABLE_DEPTH];
    logic [sdt_pkg::TIME_W-1:0] shadow_last_seen [TABLE_DEPTH];
    logic [sdt_pkg::TIME_W-1:0] shadow_first     [TABLE_DEPTH];

    t_sighting_result pending_words [$];
    int unsigned      mismatch_count = 0;
    int unsigned      words_seen = 0;
    int unsigned      items_sent = 0;

    seen_device_table_lru #(
        .ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Table lookup and LRU replacement on the shadow copy
    function automatic t_sighting_result record_sighting(
        input logic [sdt_pkg::ADDR_W-1:0] addr,
        input logic [sdt_pkg::TIME_W-1:0] now
    );
        t_sighting_result           res;
        int                         idx;
        logic                       found;
        logic [sdt_pkg::TIME_W-1:0] oldest;
        res    = '0;
        idx    = 0;
        found  = 1'b0;
        oldest = now;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!found && shadow_valid[i] && shadow_addr[i] == addr) begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found) begin
            shadow_last_seen[idx] = now;
        end else begin
            // lowest free slot wins, else strictly oldest below now, else slot 0
            found = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!found) begin
                    if (!shadow_valid[i]) begin
                        idx   = i;
                        found = 1'b1;
                    end else if (shadow_last_seen[i] < oldest) begin
                        oldest = shadow_last_seen[i];
                        idx    = i;
                    end
                end
            end
            res.evicted           = shadow_valid[idx];
            shadow_valid[idx]     = 1'b1;
            shadow_addr[idx]      = addr;
            shadow_last_seen[idx] = now;
            shadow_first[idx]     = now;
            found                 = 1'b0;
        end
        res.hit        = found;
        res.slot       = idx[sdt_pkg::SLOT_W-1:0];
        res.first_seen = shadow_first[idx];
        return res;
    endfunction

    // Offer one sighting after a random gap and wait for the handshake
    task automatic send_sighting(input logic [sdt_pkg::ADDR_W-1:0] addr,
                                 input logic [sdt_pkg::TIME_W-1:0] now,
                                 input logic typed, input t_sighting_result want);
        int unsigned      gap;
        t_sighting_result res;
        gap = (((items_sent / 50) % 5) == 4) ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {now, addr};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        res = record_sighting(addr, now);
        pending_words.push_back(typed ? want : res);
        items_sent++;
    endtask

    // Stop offering and wait until every word is back
    task automatic drain_table;
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, one long hold-off, field compare
    initial begin : result_sink
        int unsigned      stall;
        logic             held;
        t_sighting_result got;
        t_sighting_result want;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (words_seen == HOLD_AT && !held) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else begin
                stall = (((words_seen / 50) % 5) == 2) ? 0 : $urandom_range(0, 9);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got.hit        = m_axis_tdata[0];
            got.slot       = m_axis_tdata[4:1];
            got.evicted    = m_axis_tdata[5];
            got.first_seen = m_axis_tdata[37:6];
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("word %0d: unexpected, got hit=%0d slot=%0d evict=%0d first=%h",
                             words_seen, got.hit, got.slot, got.evicted,
                             got.first_seen);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("word %0d: expected hit=%0d slot=%0d evict=%0d first=%h",
                                 words_seen, want.hit, want.slot, want.evicted,
                                 want.first_seen);
                        $display("          got      hit=%0d slot=%0d evict=%0d first=%h",
                                 got.hit, got.slot, got.evicted, got.first_seen);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed rows, random sightings, drain
    initial begin : stimulus
        logic [sdt_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];
        logic [sdt_pkg::ADDR_W-1:0] addr;
        logic [sdt_pkg::TIME_W-1:0] clock_now;
        int unsigned                pick;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_valid[i]     = 1'b0;
            shadow_addr[i]      = '0;
            shadow_last_seen[i] = '0;
            shadow_first[i]     = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < ROW_COUNT; r++)
            send_sighting(DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].now,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // Mostly a small pool of devices with advancing time, so hits and
        // evictions both occur; the rest is new devices and time jumps
        clock_now = 32'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0)
                for (int p = 0; p < POOL_SIZE; p++)
                    addr_pool[p] = sdt_pkg::ADDR_W'({$urandom, $urandom});
            if (n == PAUSE_AT)
                drain_table();
            pick = $urandom_range(0, 99);
            if (pick < 80)
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                addr = sdt_pkg::ADDR_W'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 70)
                clock_now = clock_now + $urandom_range(1, 5);
            else if (pick < 85)
                clock_now = clock_now;
            else if (pick < 93)
                clock_now = clock_now - $urandom_range(1, 20);
            else
                clock_now = $urandom;
            send_sighting(addr, clock_now, 1'b0, UNTYPED);
        end

        drain_table();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
